@@ design/btps_pkg.sv @@
`default_nettype none

package btps_pkg;

  localparam int BLK = 8;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 1'd1;

  typedef logic [BLK-1:0][7:0]   blk_t;
  typedef logic [2*BLK-1:0][7:0] frame_t;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_HELD,
    OP_NEW,
    OP_BOTH,
    OP_TAIL
  } op_t;

  typedef struct packed {
    op_t        op;
    blk_t       held;
    blk_t       fresh;
    logic [4:0] cnt;
    logic [2:0] r;
    logic       dir;
    logic       eop;
  } job_t;

  function automatic blk_t transpose8(blk_t a);
    blk_t t;
    for (int i = 0; i < BLK; i++) begin
      for (int j = 0; j < BLK; j++) begin
        t[i][j] = a[j][i];
      end
    end
    return t;
  endfunction

  // tail window overlaps the last block by 8 - r bytes
  function automatic frame_t tail_frame(blk_t held, blk_t fresh, logic [2:0] r, logic dir);
    frame_t f;
    f = {fresh, held};
    if (!dir) begin
      f[BLK-1:0] = transpose8(f[BLK-1:0]);
      f[r +: BLK] = transpose8(f[r +: BLK]);
    end else begin
      f[r +: BLK] = transpose8(f[r +: BLK]);
      f[BLK-1:0] = transpose8(f[BLK-1:0]);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ design/btps_front.sv @@
`default_nettype none

module btps_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          direction,
  input  logic          bypass,
  output logic          job_push,
  output btps_pkg::job_t job,
  input  logic          q_full
);
  import btps_pkg::*;

  logic [6:0][7:0] pending;
  logic [6:0][7:0] pending_next;
  blk_t            held;
  blk_t            held_next;
  logic [2:0]      fill;
  logic [2:0]      fill_next;
  logic            held_valid;
  logic            held_valid_next;
  blk_t            fresh;
  logic [2:0]      r;
  logic            accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign r      = fill + 3'd1;

  always_comb begin
    for (int i = 0; i < BLK - 1; i++) begin
      fresh[i] = (fill == 3'(i)) ? data_byte : pending[i];
    end
    fresh[BLK-1] = data_byte;

    job.op    = OP_PASS;
    job.held  = held;
    job.fresh = fresh;
    job.cnt   = {2'b00, r};
    job.r     = r;
    job.dir   = direction;
    job.eop   = last_byte;
    job_push  = 1'b0;

    pending_next    = pending;
    held_next       = held;
    fill_next       = fill;
    held_valid_next = held_valid;

    if (accept) begin
      if (bypass) begin
        job_push     = 1'b1;
        job.fresh[0] = data_byte;
        job.cnt      = 5'd1;
        if (last_byte) begin
          fill_next       = 3'd0;
          held_valid_next = 1'b0;
        end
      end else if (fill == 3'd7) begin
        fill_next = 3'd0;
        if (last_byte) begin
          job_push        = 1'b1;
          job.op          = held_valid ? OP_BOTH : OP_NEW;
          job.cnt         = held_valid ? 5'd16 : 5'd8;
          held_valid_next = 1'b0;
        end else begin
          job_push        = held_valid;
          job.op          = OP_HELD;
          job.cnt         = 5'd8;
          held_next       = fresh;
          held_valid_next = 1'b1;
        end
      end else if (!last_byte) begin
        pending_next[fill] = data_byte;
        fill_next          = r;
      end else begin
        job_push  = 1'b1;
        fill_next = 3'd0;
        if (held_valid) begin
          job.op          = OP_TAIL;
          job.cnt         = {2'b00, r} + 5'd8;
          held_valid_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pending <= pending_next;
    held    <= held_next;
    if (rst) begin
      fill       <= 3'd0;
      held_valid <= 1'b0;
    end else begin
      fill       <= fill_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ design/btps_queue.sv @@
`default_nettype none

module btps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  btps_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd,
  output btps_pkg::job_t rd_job,
  output logic           empty
);
  import btps_pkg::*;

  job_t                 entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;
  logic                 do_wr;
  logic                 do_rd;

  assign full   = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/btps_back.sv @@
`default_nettype none

module btps_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  btps_pkg::job_t q_job,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           end_of_packet
);
  import btps_pkg::*;

  frame_t     frame;
  frame_t     frame_in;
  logic [4:0] cnt;
  logic [3:0] idx;
  logic       eop;
  logic       valid;
  logic       last_out;
  logic       take;
  logic       done;
  logic       load;

  assign last_out      = ({1'b0, idx} == cnt - 5'd1);
  assign take          = pop && valid;
  assign done          = take && last_out;
  assign load          = !q_empty && (!valid || done);
  assign q_pop         = load;
  assign empty         = !valid;
  assign out_byte      = frame[idx];
  assign end_of_packet = eop && last_out;

  always_comb begin
    frame_in = {q_job.fresh, q_job.held};
    case (q_job.op)
      OP_PASS: frame_in[BLK-1:0] = q_job.fresh;
      OP_HELD: frame_in[BLK-1:0] = transpose8(q_job.held);
      OP_NEW:  frame_in[BLK-1:0] = transpose8(q_job.fresh);
      OP_BOTH: frame_in = {transpose8(q_job.fresh), transpose8(q_job.held)};
      OP_TAIL: frame_in = tail_frame(q_job.held, q_job.fresh, q_job.r, q_job.dir);
      default: frame_in = {q_job.fresh, q_job.held};
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_in;
      cnt   <= q_job.cnt;
      eop   <= q_job.eop;
      idx   <= 4'd0;
    end else if (take) begin
      idx <= idx + 4'd1;
    end
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (done) begin
      valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/bit_transpose_packet_scrambler.sv @@
// Packet scrambler that replaces each 8-byte block with its 8x8 bit transpose,
// plus one overlapping transpose of the last 8 bytes when the packet length is
// not a multiple of 8 (after the blocks when scrambling, before them when
// descrambling). Input takes one byte per cycle while full is low; results
// leave one per cycle on pop, in packet order. Output lags input by about one
// block, since the latest block is held until the packet end shows whether the
// tail overlaps it. The final byte of a packet releases up to 16 results at
// once; the two-entry job queue between the input side and the output side can
// then fill when short jobs follow, and full rises until the output side drains.
// Packets under 8 bytes, and every byte while bypass is set, come out unchanged.
`default_nettype none

module bit_transpose_packet_scrambler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           end_of_packet,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [btps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import btps_pkg::*;

  logic direction;
  logic bypass;
  logic job_push;
  job_t job;
  job_t q_job;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      bypass    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIRECTION: direction <= cfg_data;
        REG_BYPASS:    bypass    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  btps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .direction (direction),
    .bypass    (bypass),
    .job_push  (job_push),
    .job       (job),
    .q_full    (q_full)
  );

  btps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (job),
    .full   (q_full),
    .rd     (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  btps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_job         (q_job),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .end_of_packet (end_of_packet)
  );

endmodule

`default_nettype wire

@@ design/btps_checker.sv @@
`default_nettype none

module btps_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       last_byte,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       end_of_packet
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_byte) |-> ##2 !empty)
    else $error("packet end transfer gave no result");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_packet)))
    else $error("waiting result changed before transfer");

endmodule

bind bit_transpose_packet_scrambler btps_checker u_checker (.*);

`default_nettype wire

@@ dv/bit_transpose_packet_scrambler_tb.sv @@
`default_nettype none

module bit_transpose_packet_scrambler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btps_pkg::*;

  typedef logic [7:0][7:0] octets_t;

  typedef struct packed {
    logic [7:0] value;
    logic       eop;
  } out_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           data_byte = 8'h00;
  logic                 last_byte = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           out_byte;
  logic                 end_of_packet;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DIRECTION;
  logic                 cfg_data = 1'b0;

  out_item_t  expected_out[$];
  int         errors = 0;
  bit         idle_on = 1'b1;
  int         pop_hold = 0;

  logic       mode_dir = 1'b0;
  logic       mode_bypass = 1'b0;
  octets_t    held_blk;
  logic [7:0] partial [7];
  int         part_cnt = 0;
  bit         blk_valid = 1'b0;

  bit_transpose_packet_scrambler dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .end_of_packet (end_of_packet),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic octets_t flip_octets(octets_t a);
    octets_t t;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        t[i] = t[i] | (((a[j] >> i) & 8'd1) << j);
      end
    end
    return t;
  endfunction

  task automatic expect_octets(input octets_t b, input bit eop_on_last);
    for (int i = 0; i < 8; i++) begin
      expected_out.push_back('{value: b[i], eop: eop_on_last && (i == 7)});
    end
  endtask

  task automatic predict_scrambled(input logic [7:0] value, input logic last);
    octets_t          blk;
    logic [15:0][7:0] frame;
    int               n;
    int               off;
    if (mode_bypass) begin
      expected_out.push_back('{value: value, eop: last});
      if (last) begin
        part_cnt = 0;
        blk_valid = 1'b0;
      end
      return;
    end
    n = part_cnt + 1;
    if (n == 8) begin
      for (int i = 0; i < 7; i++) blk[i] = partial[i];
      blk[7] = value;
      if (blk_valid) expect_octets(flip_octets(held_blk), 1'b0);
      part_cnt = 0;
      if (last) begin
        expect_octets(flip_octets(blk), 1'b1);
        blk_valid = 1'b0;
      end else begin
        held_blk = blk;
        blk_valid = 1'b1;
      end
    end else if (!last) begin
      partial[n-1] = value;
      part_cnt = n;
    end else begin
      part_cnt = 0;
      if (!blk_valid) begin
        for (int i = 0; i < n - 1; i++) expected_out.push_back('{value: partial[i], eop: 1'b0});
        expected_out.push_back('{value: value, eop: 1'b1});
      end else begin
        frame = '0;
        for (int i = 0; i < 8; i++) frame[i] = held_blk[i];
        for (int i = 0; i < n - 1; i++) frame[8+i] = partial[i];
        frame[8+n-1] = value;
        // scramble: block first, then the overlapping tail; descramble the other way
        for (int p = 0; p < 2; p++) begin
          off = ((p == 0) ^ mode_dir) ? 0 : n;
          for (int i = 0; i < 8; i++) blk[i] = frame[off+i];
          blk = flip_octets(blk);
          for (int i = 0; i < 8; i++) frame[off+i] = blk[i];
        end
        for (int i = 0; i < 8 + n; i++) begin
          expected_out.push_back('{value: frame[i], eop: i == 7 + n});
        end
        blk_valid = 1'b0;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    data_byte <= value;
    last_byte <= last;
    do @(posedge clk); while (full);
    predict_scrambled(value, last);
  endtask

  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // hold off until every expected byte has come out and the datapath is quiet
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (32) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DIRECTION) mode_dir = val;
    else mode_bypass = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_packets(input int n_items);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 2) len = $urandom_range(1, 7);
      else if (r < 4) len = 8 * $urandom_range(1, 2);
      else if (r == 4) len = $urandom_range(17, 40);
      else len = $urandom_range(9, 16);
      send_packet(len);
      sent += len;
    end
  endtask

  task automatic test_short_packets();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_full_block();
    logic [7:0] pattern [8];
    pattern = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h01, 8'h80};
    for (int i = 0; i < 8; i++) send_byte(pattern[i], i == 7);
  endtask

  task automatic test_tail_scramble();
    for (int i = 0; i < 9; i++) send_byte(8'(8'h11 * i + 8'h3C), i == 8);
  endtask

  task automatic test_bypass_drop();
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    write_reg(REG_BYPASS, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    write_reg(REG_BYPASS, 1'b0);
  endtask

  task automatic test_scramble_traffic();
    write_reg(REG_DIRECTION, 1'b0);
    idle_on = 1'b1;
    run_packets(120);
  endtask

  task automatic test_descramble_traffic();
    write_reg(REG_DIRECTION, 1'b1);
    idle_on = 1'b1;
    run_packets(120);
  endtask

  task automatic test_back_to_back_traffic();
    idle_on = 1'b0;
    run_packets(30);
    write_reg(REG_DIRECTION, 1'b0);
    run_packets(30);
    idle_on = 1'b1;
  endtask

  task automatic test_bypass_traffic();
    write_reg(REG_BYPASS, 1'b1);
    run_packets(40);
    write_reg(REG_BYPASS, 1'b0);
  endtask

  task automatic test_bypass_splice();
    int head;
    int mid;
    int rest;
    repeat (8) begin
      head = $urandom_range(1, 12);
      mid = $urandom_range(1, 4);
      rest = $urandom_range(1, 10);
      for (int i = 0; i < head; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      write_reg(REG_BYPASS, 1'b1);
      for (int i = 0; i < mid; i++) begin
        send_byte(8'($urandom_range(0, 255)),
                  (i == mid - 1) && ($urandom_range(0, 2) == 0));
      end
      write_reg(REG_BYPASS, 1'b0);
      write_reg(REG_DIRECTION, 1'($urandom_range(0, 1)));
      for (int i = 0; i < rest; i++) send_byte(8'($urandom_range(0, 255)), i == rest - 1);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual out_byte=%02h eop=%0b",
                 $time, out_byte, end_of_packet);
        errors++;
      end else begin
        want = expected_out.pop_front();
        if (out_byte !== want.value) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                   $time, want.value, out_byte);
          errors++;
        end
        if (end_of_packet !== want.eop) begin
          $display("%0t: end_of_packet mismatch: expected %0b, actual %0b",
                   $time, want.eop, end_of_packet);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_short_packets();
    test_full_block();
    test_tail_scramble();
    test_bypass_drop();
    test_scramble_traffic();
    test_descramble_traffic();
    test_back_to_back_traffic();
    test_bypass_traffic();
    test_bypass_splice();
    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
